// ----- hw/rtl/msx_pkg.sv -----
// shared types and constants of the mips subset executor
package msx_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned REG_AW     = 5;
  localparam int unsigned NUM_REGS   = 32;
  localparam int unsigned DMEM_WORDS = 262144;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);
  localparam int unsigned MEM_IDX_W  = 18;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [29:0]        DMEM_LIMIT = 30'(DMEM_WORDS);
  localparam logic [DMEM_AW-1:0] DMEM_LAST  = DMEM_AW'(DMEM_WORDS - 1);
  localparam logic [XLEN-1:0]    DATA_BASE  = 32'h1000_0000;
  localparam logic [XLEN-1:0]    PC_STEP    = 32'd4;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR  = 6'h25;
  localparam logic [5:0] FN_SLT = 6'h2A;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNK   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [4:0] {
    K_NOP, K_UNK, K_ADD, K_SUB, K_AND, K_OR, K_SLT,
    K_ADDI, K_ANDI, K_ORI, K_LUI, K_SLTI,
    K_BEQ, K_BNE, K_J, K_LW, K_SW
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [REG_AW-1:0] rs;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] dst;
    logic [XLEN-1:0]   imm;
  } uop_t;

  typedef struct packed {
    logic [XLEN-1:0]      mem_value;
    logic [MEM_IDX_W-1:0] mem_index;
    logic                 mem_write;
    logic [XLEN-1:0]      reg_value;
    logic [REG_AW-1:0]    reg_index;
    logic                 reg_write;
    logic [1:0]           status;
    logic [XLEN-1:0]      next_pc;
  } result_t;

  localparam int unsigned RES_W   = $bits(result_t);
  localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ----- hw/rtl/msx_ram.sv -----
// generic single write port ram with registered read
module msx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/msx_front.sv -----
// instruction intake and decode into micro-ops
module msx_front import msx_pkg::*; (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [XLEN-1:0] s_tdata,   // instruction
  input  logic            q_full,
  input  logic            clr_busy,
  output logic            push,
  output uop_t            push_uop
);

  logic [5:0]      op;
  logic [5:0]      fn;
  logic [XLEN-1:0] simm;
  logic [XLEN-1:0] zimm;

  assign s_tready = !q_full && !clr_busy;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    op   = s_tdata[31:26];
    fn   = s_tdata[5:0];
    simm = {{16{s_tdata[15]}}, s_tdata[15:0]};
    zimm = {16'b0, s_tdata[15:0]};
    push_uop.rs   = s_tdata[25:21];
    push_uop.rt   = s_tdata[20:16];
    push_uop.dst  = s_tdata[20:16];
    push_uop.imm  = simm;
    push_uop.kind = K_UNK;
    unique case (op)
      OP_RTYPE: begin
        push_uop.dst = s_tdata[15:11];
        unique case (fn)
          FN_ADD:  push_uop.kind = K_ADD;
          FN_SUB:  push_uop.kind = K_SUB;
          FN_AND:  push_uop.kind = K_AND;
          FN_OR:   push_uop.kind = K_OR;
          FN_SLT:  push_uop.kind = K_SLT;
          default: begin
            if (s_tdata == '0) begin
              push_uop.kind = K_NOP;
            end else begin
              push_uop.kind = K_UNK;
            end
          end
        endcase
      end
      OP_ADDI: push_uop.kind = K_ADDI;
      OP_SLTI: push_uop.kind = K_SLTI;
      OP_ANDI: begin
        push_uop.kind = K_ANDI;
        push_uop.imm  = zimm;
      end
      OP_ORI: begin
        push_uop.kind = K_ORI;
        push_uop.imm  = zimm;
      end
      OP_LUI: begin
        push_uop.kind = K_LUI;
        push_uop.imm  = {s_tdata[15:0], 16'b0};
      end
      // branch offset already holds the +4 of the fall-through pc
      OP_BEQ: begin
        push_uop.kind = K_BEQ;
        push_uop.imm  = {simm[29:0], 2'b00} + PC_STEP;
      end
      OP_BNE: begin
        push_uop.kind = K_BNE;
        push_uop.imm  = {simm[29:0], 2'b00} + PC_STEP;
      end
      OP_J: begin
        push_uop.kind = K_J;
        push_uop.imm  = {4'b0, s_tdata[25:0], 2'b00};
      end
      // data base folded into the offset
      OP_LW: begin
        push_uop.kind = K_LW;
        push_uop.imm  = simm - DATA_BASE;
      end
      OP_SW: begin
        push_uop.kind = K_SW;
        push_uop.imm  = simm - DATA_BASE;
      end
      default: push_uop.kind = K_UNK;
    endcase
  end

endmodule

// ----- hw/rtl/msx_queue.sv -----
// short micro-op queue between decode and execute
module msx_queue import msx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  uop_t push_uop,
  output logic full,
  input  logic pop,
  output logic valid,
  output uop_t head
);

  uop_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

  assign full  = (count == CNT_FULL);
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/msx_back.sv -----
// execute stage: register file, data memory, pc and result register
module msx_back import msx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  uop_t    head,
  output logic    pop,
  output logic    clr_busy,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t m_res
);

  typedef enum logic [2:0] {
    ST_READ = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [XLEN-1:0]   pc;
  logic [NUM_REGS-1:0] rf_valid;
  logic [DMEM_AW-1:0] clr_cnt;

  logic [XLEN-1:0]    ra_data;
  logic [XLEN-1:0]    rb_data;
  logic [XLEN-1:0]    dm_rdata;
  logic [XLEN-1:0]    a;
  logic [XLEN-1:0]    b;
  logic [XLEN-1:0]    opb;
  logic [XLEN-1:0]    pc4;
  logic [XLEN-1:0]    br_tgt;
  logic [XLEN-1:0]    addr_off;
  logic               addr_ok;
  logic [DMEM_AW-1:0] dm_idx;
  logic               is_load;
  logic               out_free;
  logic               done;
  result_t            res;

  logic               rf_we;
  logic               dm_we;
  logic [DMEM_AW-1:0] dm_waddr;
  logic [XLEN-1:0]    dm_wdata;

  msx_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(res.reg_index), .wdata(res.reg_value),
    .raddr(head.rs), .rdata(ra_data)
  );

  msx_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(res.reg_index), .wdata(res.reg_value),
    .raddr(head.rt), .rdata(rb_data)
  );

  msx_ram #(.WIDTH(XLEN), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_idx), .rdata(dm_rdata)
  );

  always_comb begin
    a        = rf_valid[head.rs] ? ra_data : '0;
    b        = rf_valid[head.rt] ? rb_data : '0;
    opb      = (head.kind inside {K_ADDI, K_SLTI, K_ANDI, K_ORI}) ? head.imm : b;
    pc4      = pc + PC_STEP;
    br_tgt   = pc + head.imm;
    addr_off = a + head.imm;
    addr_ok  = (addr_off[31:2] < DMEM_LIMIT);
    dm_idx   = addr_off[DMEM_AW+1:2];
    is_load  = (head.kind == K_LW) && addr_ok;

    res           = '0;
    res.next_pc   = pc4;
    res.status    = STAT_OK;
    res.reg_index = head.dst;
    unique case (head.kind) inside
      K_NOP: ;
      K_ADD, K_ADDI: begin
        res.reg_write = 1'b1;
        res.reg_value = a + opb;
      end
      K_SUB: begin
        res.reg_write = 1'b1;
        res.reg_value = a - b;
      end
      K_AND, K_ANDI: begin
        res.reg_write = 1'b1;
        res.reg_value = a & opb;
      end
      K_OR, K_ORI: begin
        res.reg_write = 1'b1;
        res.reg_value = a | opb;
      end
      K_SLT, K_SLTI: begin
        res.reg_write = 1'b1;
        res.reg_value = {31'b0, ($signed(a) < $signed(opb))};
      end
      K_LUI: begin
        res.reg_write = 1'b1;
        res.reg_value = head.imm;
      end
      K_BEQ: res.next_pc = (a == b) ? br_tgt : pc4;
      K_BNE: res.next_pc = (a != b) ? br_tgt : pc4;
      K_J:   res.next_pc = {pc4[31:28], head.imm[27:0]};
      K_LW: begin
        if (addr_ok) begin
          res.reg_write = 1'b1;
          res.reg_value = dm_rdata;
        end else begin
          res.status = STAT_RANGE;
        end
      end
      K_SW: begin
        if (addr_ok) begin
          res.mem_write = 1'b1;
          res.mem_index = MEM_IDX_W'(dm_idx);
          res.mem_value = b;
        end else begin
          res.status = STAT_RANGE;
        end
      end
      default: res.status = STAT_UNK;
    endcase
    if (!res.reg_write) begin
      res.reg_index = '0;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign done     = out_free && ((state == ST_EXEC && !is_load) || state == ST_LOAD);
  assign pop      = done;
  assign rf_we    = done && res.reg_write;
  assign dm_we    = clr_busy || (done && res.mem_write);
  assign dm_waddr = clr_busy ? clr_cnt : dm_idx;
  assign dm_wdata = clr_busy ? '1 : b;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_READ: if (q_valid && !clr_busy) state_next = ST_EXEC;
      ST_EXEC: begin
        if (is_load) begin
          state_next = ST_LOAD;
        end else if (done) begin
          state_next = ST_READ;
        end
      end
      ST_LOAD: if (done) state_next = ST_READ;
      default: state_next = ST_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_READ;
      pc       <= '0;
      rf_valid <= '0;
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == DMEM_LAST) begin
          clr_busy <= 1'b0;
        end
      end
      if (done) begin
        pc       <= res.next_pc;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (rf_we) begin
        rf_valid[res.reg_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_res <= res;
    end
  end

`ifndef SYNTH
  a_clr_idle: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (state == ST_READ && !done))
    else $error("execute active during memory clear");

  a_busy_has_item: assert property (@(posedge clk) disable iff (rst)
    (state != ST_READ) |-> q_valid)
    else $error("execute stage without queued micro-op");

  a_load_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ($past(state) == ST_EXEC || $past(state) == ST_LOAD))
    else $error("load state entered out of order");

  a_rf_marked: assert property (@(posedge clk) disable iff (rst)
    rf_we |=> rf_valid[$past(res.reg_index)])
    else $error("written register not marked valid");

  a_load_holds_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && !out_free) |=> state == ST_LOAD)
    else $error("load left while result register full");
`endif

endmodule

// ----- hw/rtl/mips_subset_instruction_executor.sv -----
// top level of the mips subset instruction executor
// Usage:
//   slave channel (s_*) takes one 32-bit instruction word per transfer, the
//   word at the current pc; master channel (m_*) gives one result per
//   instruction: next pc, status, and the register and memory write made.
//   Results leave in instruction order.
// Flow:
//   an instruction is decoded on intake into a two-entry micro-op queue;
//   execute then reads the register file, then executes and writes back
//   (an in-range lw adds a data memory read). The result appears in the
//   output register the cycle after execute completes. Intake runs at one
//   per cycle while the queue has room and the memory sweep is done.
// Reset:
//   registers and pc read as zero. Data memory is then swept to all ones,
//   one word per cycle over all 262144 words; s_tready stays low during the sweep.
// Stalls:
//   when m_tready is low the result is held, execute waits, and the queue
//   fills before s_tready drops.
module mips_subset_instruction_executor import msx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [XLEN-1:0]    s_tdata,  // instruction
  output logic               m_tvalid,
  input  logic               m_tready,
  // next_pc, status, reg_write, reg_index, reg_value, mem_write, mem_index, mem_value
  output logic [TDATA_W-1:0] m_tdata
);

  logic    q_full;
  logic    clr_busy;
  logic    push;
  uop_t    push_uop;
  logic    pop;
  logic    q_valid;
  uop_t    head;
  result_t m_res;

  msx_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .q_full(q_full), .clr_busy(clr_busy), .push(push), .push_uop(push_uop)
  );

  msx_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_uop(push_uop), .full(q_full),
    .pop(pop), .valid(q_valid), .head(head)
  );

  msx_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .head(head), .pop(pop),
    .clr_busy(clr_busy), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(m_res)
  );

  assign m_tdata = TDATA_W'(m_res);

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the mips subset instruction executor stream block
module tb;
  import msx_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [XLEN-1:0]    s_tdata = '0;  // instruction
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // next_pc, status, reg_write, reg_index, reg_value, mem_write, mem_index, mem_value
  logic [TDATA_W-1:0] m_tdata;

  logic [31:0] pending_words[$];
  result_t     expected_results[$];
  int          words_total;
  int          words_accepted;
  int          error_count;

  logic [31:0] gpr[NUM_REGS];
  logic [31:0] arch_pc;
  logic [31:0] mem_model[int unsigned];

  int gap_left;
  int stall_left;
  bit quiet_send;
  bit quiet_recv;

  mips_subset_instruction_executor u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd);
    return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 12));
  endfunction

  // architectural state update for one instruction word
  function automatic result_t execute_word(logic [31:0] w);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc4;
    logic [31:0] idx;
    result_t     r;
    op   = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    fn   = w[5:0];
    imm  = {16'd0, w[15:0]};
    simm = {{16{w[15]}}, w[15:0]};
    a    = gpr[rs];
    b    = gpr[rt];
    pc4  = arch_pc + PC_STEP;
    r = '0;
    r.next_pc = pc4;
    r.status  = STAT_OK;
    case (op) inside
      OP_RTYPE: begin
        r.reg_write = 1'b1;
        r.reg_index = rd;
        case (fn)
          FN_ADD: r.reg_value = a + b;
          FN_SUB: r.reg_value = a - b;
          FN_AND: r.reg_value = a & b;
          FN_OR:  r.reg_value = a | b;
          FN_SLT: r.reg_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          default: begin
            r.reg_write = 1'b0;
            r.reg_index = '0;
            if (w != '0) r.status = STAT_UNK;
          end
        endcase
      end
      OP_ADDI: begin
        r.reg_write = 1'b1; r.reg_index = rt; r.reg_value = a + simm;
      end
      OP_ANDI: begin
        r.reg_write = 1'b1; r.reg_index = rt; r.reg_value = a & imm;
      end
      OP_ORI: begin
        r.reg_write = 1'b1; r.reg_index = rt; r.reg_value = a | imm;
      end
      OP_LUI: begin
        r.reg_write = 1'b1; r.reg_index = rt; r.reg_value = {w[15:0], 16'd0};
      end
      OP_SLTI: begin
        r.reg_write = 1'b1; r.reg_index = rt;
        r.reg_value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
      end
      OP_BEQ: begin
        if (a == b) r.next_pc = pc4 + (simm << 2);
      end
      OP_BNE: begin
        if (a != b) r.next_pc = pc4 + (simm << 2);
      end
      OP_J: r.next_pc = (pc4 & 32'hF000_0000) | {4'd0, w[25:0], 2'b00};
      OP_LW, OP_SW: begin
        idx = (a + simm - DATA_BASE) >> 2;
        if (idx >= DMEM_WORDS) begin
          r.status = STAT_RANGE;
        end else if (op == OP_LW) begin
          r.reg_write = 1'b1;
          r.reg_index = rt;
          r.reg_value = mem_model.exists(idx) ? mem_model[idx] : 32'hFFFF_FFFF;
        end else begin
          mem_model[idx] = b;
          r.mem_write = 1'b1;
          r.mem_index = idx[MEM_IDX_W-1:0];
          r.mem_value = b;
        end
      end
      default: r.status = STAT_UNK;
    endcase
    if (r.reg_write) gpr[r.reg_index] = r.reg_value;
    arch_pc = r.next_pc;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // instruction driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(execute_word(s_tdata));
        words_accepted++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_words.pop_front();
          if ($urandom_range(0, 39) == 0) quiet_send = ~quiet_send;
          gap_left <= draw_wait(quiet_send);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    int      s;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RES_W-1:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, got);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("next_pc", want.next_pc, got.next_pc);
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
          check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
          check_field("reg_value", want.reg_value, got.reg_value);
          check_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
          check_field("mem_index", 32'(want.mem_index), 32'(got.mem_index));
          check_field("mem_value", want.mem_value, got.mem_value);
        end
        if ($urandom_range(0, 39) == 0) quiet_recv = ~quiet_recv;
        s = draw_wait(quiet_recv);
      end else begin
        s = (stall_left > 0) ? stall_left - 1 : 0;
      end
      m_tready   <= (s == 0);
      stall_left <= s;
    end
  end

  initial begin
    int          pick;
    int          n;
    logic [4:0]  base;
    logic [4:0]  rt;
    logic [15:0] off;
    logic [4:0]  rnd_rs;
    logic [4:0]  rnd_rt;
    logic [4:0]  rnd_rd;
    logic [15:0] rnd_imm;
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
    arch_pc        = '0;
    words_accepted = 0;
    error_count    = 0;

    // directed: field extremes, every operation, range and unknown cases
    pending_words.push_back(32'h0000_0000);
    pending_words.push_back(i_word(OP_LUI, 5'd0, 5'd1, 16'h1000));
    pending_words.push_back(i_word(OP_LW, 5'd1, 5'd3, 16'h0000));
    pending_words.push_back(i_word(OP_ADDI, 5'd0, 5'd2, 16'hFFFF));
    pending_words.push_back(i_word(OP_ADDI, 5'd0, 5'd4, 16'h7FFF));
    pending_words.push_back(r_word(FN_ADD, 5'd2, 5'd4, 5'd5));
    pending_words.push_back(r_word(FN_SUB, 5'd4, 5'd2, 5'd6));
    pending_words.push_back(r_word(FN_AND, 5'd2, 5'd4, 5'd7));
    pending_words.push_back(r_word(FN_OR, 5'd0, 5'd4, 5'd8));
    pending_words.push_back(r_word(FN_SLT, 5'd2, 5'd4, 5'd31));
    pending_words.push_back(i_word(OP_SLTI, 5'd4, 5'd10, 16'h8000));
    pending_words.push_back(i_word(OP_ANDI, 5'd2, 5'd11, 16'hFFFF));
    pending_words.push_back(i_word(OP_ORI, 5'd0, 5'd12, 16'h8000));
    pending_words.push_back(i_word(OP_SW, 5'd1, 5'd4, 16'h0000));
    pending_words.push_back(i_word(OP_LW, 5'd1, 5'd13, 16'h0000));
    pending_words.push_back(i_word(OP_LUI, 5'd0, 5'd14, 16'h1010));
    pending_words.push_back(i_word(OP_SW, 5'd14, 5'd2, 16'hFFFC));
    pending_words.push_back(i_word(OP_LW, 5'd14, 5'd15, 16'h0000));
    pending_words.push_back(i_word(OP_LW, 5'd1, 5'd15, 16'hFFFC));
    pending_words.push_back(i_word(OP_ADDI, 5'd0, 5'd0, 16'h0005));
    pending_words.push_back(i_word(OP_BEQ, 5'd0, 5'd0, 16'h7FFF));
    pending_words.push_back(i_word(OP_BNE, 5'd0, 5'd0, 16'h0001));
    pending_words.push_back(i_word(OP_BNE, 5'd2, 5'd0, 16'h8000));
    pending_words.push_back({OP_J, 26'h3FF_FFFF});
    pending_words.push_back(32'hFFFF_FFFF);
    pending_words.push_back(32'h0000_0040);
    pending_words.push_back(r_word(6'h21, 5'd1, 5'd2, 5'd3));

    while (pending_words.size() < 1600) begin
      pick    = $urandom_range(0, 9);
      rnd_rs  = 5'($urandom());
      rnd_rt  = 5'($urandom());
      rnd_rd  = 5'($urandom());
      rnd_imm = 16'($urandom());
      case (pick) inside
        0, 1: pending_words.push_back($urandom());
        2, 3: begin
          case ($urandom_range(0, 5))
            0: pending_words.push_back(r_word(FN_ADD, rnd_rs, rnd_rt, rnd_rd));
            1: pending_words.push_back(r_word(FN_SUB, rnd_rs, rnd_rt, rnd_rd));
            2: pending_words.push_back(r_word(FN_AND, rnd_rs, rnd_rt, rnd_rd));
            3: pending_words.push_back(r_word(FN_OR, rnd_rs, rnd_rt, rnd_rd));
            4: pending_words.push_back(r_word(FN_SLT, rnd_rs, rnd_rt, rnd_rd));
            default: pending_words.push_back({OP_RTYPE, 20'($urandom()), 6'($urandom())});
          endcase
        end
        4: begin
          case ($urandom_range(0, 4))
            0: pending_words.push_back(i_word(OP_ADDI, rnd_rs, rnd_rt, rnd_imm));
            1: pending_words.push_back(i_word(OP_ANDI, rnd_rs, rnd_rt, rnd_imm));
            2: pending_words.push_back(i_word(OP_ORI, rnd_rs, rnd_rt, rnd_imm));
            3: pending_words.push_back(i_word(OP_LUI, rnd_rs, rnd_rt, rnd_imm));
            default: pending_words.push_back(i_word(OP_SLTI, rnd_rs, rnd_rt, rnd_imm));
          endcase
        end
        5: pending_words.push_back(i_word($urandom_range(0, 1) ? OP_BEQ : OP_BNE,
                                          rnd_rs, rnd_rt, rnd_imm));
        6: pending_words.push_back({OP_J, 26'($urandom())});
        default: begin
          // load/store run around a freshly built data pointer
          base = 5'($urandom());
          pending_words.push_back(i_word(OP_LUI, 5'd0, base,
                                         16'h1000 + 16'($urandom_range(0, 15))));
          if ($urandom_range(0, 1))
            pending_words.push_back(i_word(OP_ORI, base, base, 16'($urandom())));
          n = $urandom_range(1, 6);
          for (int k = 0; k < n; k++) begin
            rt = 5'($urandom());
            if ($urandom_range(0, 9) == 0) off = 16'($urandom());
            else off = 16'($urandom_range(0, 7) * 4 + $urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) begin
              pending_words.push_back(i_word(OP_LUI, 5'd0, rt, 16'($urandom())));
              pending_words.push_back(i_word(OP_ORI, rt, rt, 16'($urandom())));
            end
            pending_words.push_back(i_word($urandom_range(0, 1) ? OP_LW : OP_SW, base, rt, off));
          end
        end
      endcase
    end
    words_total = pending_words.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (words_accepted < words_total || expected_results.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/msx_pkg.sv
hw/rtl/msx_ram.sv
hw/rtl/msx_front.sv
hw/rtl/msx_queue.sv
hw/rtl/msx_back.sv
hw/rtl/mips_subset_instruction_executor.sv
tb/tb.sv
